// File: hw/rtl/mfag_pkg.sv
// mfag_pkg: shared types and constants of the macroblock fetch address generator
// used by the channel interfaces and the top level

`default_nettype none

package mfag_pkg;

   localparam int ADDR_W      = 25;
   localparam int MB_NUM_W    = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_IN_MBS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_IN_MBS = 1'b1;

   // last sample index inside a luma and a chroma block
   localparam logic [3:0] LUMA_LAST   = 4'd15;
   localparam logic [3:0] CHROMA_LAST = 4'd7;

   typedef enum logic [1:0] {
      PLANE_Y  = 2'd0,
      PLANE_CB = 2'd1,
      PLANE_CR = 2'd2
   } plane_type;

   typedef struct packed {
      logic restart;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   byte_address;
      plane_type           plane;
      logic [3:0]          row_in_block;
      logic [3:0]          col_in_block;
      logic [MB_NUM_W-1:0] mb_number;
      logic                last_of_macroblock;
      logic                last_of_frame;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hw/rtl/mfag_channels.sv
// mfag_channels: valid/ready channel interfaces for request and response words
// depends on mfag_pkg

`default_nettype none

interface mfag_req_if import mfag_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface mfag_rsp_if import mfag_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/macroblock_fetch_address_generator.sv
// macroblock_fetch_address_generator: sample addresses of a planar 4:2:0 frame
// in macroblock order; depends on mfag_pkg and mfag_channels
//
// Usage: every word accepted on req_channel yields exactly one word on
// rsp_channel: the byte address of the current sample, its plane, its row
// and column in the block, the macroblock number and end-of-macroblock /
// end-of-frame flags. A word with restart set goes back to macroblock 0,
// luma sample (0,0) before it is emitted. Each macroblock gives 256 luma,
// 64 Cb and 64 Cr addresses, then the walk moves on in raster order and
// wraps after the last macroblock.
// The response is registered in the output register in the cycle after the
// request is accepted. One word per cycle; the position
// counters and one stride multiplier sit between the request and the
// output register. The output register is reloaded in the same cycle it
// is taken, so a stalled receiver only holds up the request side.
// Frame size is set through csr_*; the user must do so only while no word
// is in flight (unchecked); the derived plane size is registered at the write.
// Reset (synchronous): position back to macroblock 0 luma, frame size
// 1x1 macroblocks, output register empty.

`default_nettype none

module macroblock_fetch_address_generator import mfag_pkg::*; #(
   parameter int MAX_MBS_PER_SIDE = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   mfag_req_if.sink                    req_channel,
   mfag_rsp_if.source                  rsp_channel
);

   // width of an effective size (1..MAX) and of a macroblock coordinate
   localparam int EW    = $clog2(MAX_MBS_PER_SIDE + 1);
   localparam int CW    = (MAX_MBS_PER_SIDE > 1) ? $clog2(MAX_MBS_PER_SIDE) : 1;
   localparam int LS_W  = 2 * EW + 8;
   localparam int PROD_W = CW + EW + 8;
   localparam int SUM_W = 2 * EW + 11;
   localparam int FULL_W = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;
   localparam int CMP_W = EW + 1;

   function automatic logic [EW-1:0] effective_mbs(input logic [CSR_DATA_W-1:0] v);
      logic [EW-1:0] r;
      if (v == '0) begin
         r = EW'(1);
      end else if (int'(v) > MAX_MBS_PER_SIDE) begin
         r = EW'(MAX_MBS_PER_SIDE);
      end else begin
         r = EW'(v);
      end
      return r;
   endfunction

   // frame size
   logic [EW-1:0]    eff_w_ff, eff_w_in;
   logic [EW-1:0]    eff_h_ff, eff_h_in;
   logic [LS_W-1:0]  luma_size_ff, luma_size_in;
   logic [EW-1:0]    csr_eff;
   logic [2*EW-1:0]  area;

   // position
   logic [CW-1:0]       mb_row_ff, mb_row_in;
   logic [CW-1:0]       mb_col_ff, mb_col_in;
   plane_type           plane_ff, plane_in;
   logic [3:0]          sample_row_ff, sample_row_in;
   logic [3:0]          sample_col_ff, sample_col_in;
   logic [MB_NUM_W-1:0] mb_counter_ff, mb_counter_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic                accept;
   logic [CW-1:0]       cur_mb_row, cur_mb_col;
   plane_type           cur_plane;
   logic [3:0]          cur_row, cur_col;
   logic [MB_NUM_W-1:0] cur_mb_counter;
   logic [3:0]          block_last;
   logic                col_end, row_end, last_mb, last_col, last_row;
   logic [CW+3:0]       row_idx, col_idx;
   logic [EW+3:0]       stride;
   logic [PROD_W-1:0]   prod;
   logic [LS_W:0]       plane_base;
   logic [FULL_W-1:0]   addr_sum;

   // configuration: derived plane size is registered with the write
   always_comb begin
      csr_eff      = effective_mbs(csr_write_data);
      eff_w_in     = eff_w_ff;
      eff_h_in     = eff_h_ff;
      area         = eff_w_ff * eff_h_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH_IN_MBS: begin
               eff_w_in = csr_eff;
               area     = csr_eff * eff_h_ff;
            end
            CSR_HEIGHT_IN_MBS: begin
               eff_h_in = csr_eff;
               area     = eff_w_ff * csr_eff;
            end
            default: begin
               eff_w_in = eff_w_ff;
            end
         endcase
      end
      luma_size_in = {area, 8'b0};
   end

   assign accept            = req_channel.valid && req_channel.ready;
   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;

   always_comb begin
      // restart zeroes the position before the sample is emitted
      if (req_channel.word.restart) begin
         cur_mb_row     = '0;
         cur_mb_col     = '0;
         cur_plane      = PLANE_Y;
         cur_row        = '0;
         cur_col        = '0;
         cur_mb_counter = '0;
      end else begin
         cur_mb_row     = mb_row_ff;
         cur_mb_col     = mb_col_ff;
         cur_plane      = plane_ff;
         cur_row        = sample_row_ff;
         cur_col        = sample_col_ff;
         cur_mb_counter = mb_counter_ff;
      end

      block_last = (cur_plane == PLANE_Y) ? LUMA_LAST : CHROMA_LAST;
      col_end    = (cur_col == block_last);
      row_end    = (cur_row == block_last);
      last_mb    = (cur_plane == PLANE_CR) && col_end && row_end;
      // a coordinate at or past the last one counts as the last
      last_col   = (CMP_W'(cur_mb_col) + CMP_W'(1)) >= CMP_W'(eff_w_ff);
      last_row   = (CMP_W'(cur_mb_row) + CMP_W'(1)) >= CMP_W'(eff_h_ff);

      // address: plane base + row * stride + column
      case (cur_plane)
         PLANE_Y: begin
            row_idx    = {cur_mb_row, cur_row};
            col_idx    = {cur_mb_col, cur_col};
            stride     = {eff_w_ff, 4'b0};
            plane_base = '0;
         end
         PLANE_CB: begin
            row_idx    = {1'b0, cur_mb_row, cur_row[2:0]};
            col_idx    = {1'b0, cur_mb_col, cur_col[2:0]};
            stride     = {1'b0, eff_w_ff, 3'b0};
            plane_base = {1'b0, luma_size_ff};
         end
         default: begin
            row_idx    = {1'b0, cur_mb_row, cur_row[2:0]};
            col_idx    = {1'b0, cur_mb_col, cur_col[2:0]};
            stride     = {1'b0, eff_w_ff, 3'b0};
            plane_base = {1'b0, luma_size_ff} + {3'b0, luma_size_ff[LS_W-1:2]};
         end
      endcase
      prod     = row_idx * stride;
      addr_sum = FULL_W'(plane_base) + FULL_W'(prod) + FULL_W'(col_idx);

      rsp_word_in.byte_address       = addr_sum[ADDR_W-1:0];
      rsp_word_in.plane              = cur_plane;
      rsp_word_in.row_in_block       = cur_row;
      rsp_word_in.col_in_block       = cur_col;
      rsp_word_in.mb_number          = cur_mb_counter;
      rsp_word_in.last_of_macroblock = last_mb;
      rsp_word_in.last_of_frame      = last_mb && last_col && last_row;

      // advance the walk
      sample_col_in = cur_col;
      sample_row_in = cur_row;
      plane_in      = cur_plane;
      mb_col_in     = cur_mb_col;
      mb_row_in     = cur_mb_row;
      mb_counter_in = cur_mb_counter;
      if (!col_end) begin
         sample_col_in = cur_col + 4'd1;
      end else begin
         sample_col_in = '0;
         if (!row_end) begin
            sample_row_in = cur_row + 4'd1;
         end else begin
            sample_row_in = '0;
            case (cur_plane)
               PLANE_Y:  plane_in = PLANE_CB;
               PLANE_CB: plane_in = PLANE_CR;
               default: begin
                  plane_in      = PLANE_Y;
                  mb_counter_in = cur_mb_counter + MB_NUM_W'(1);
                  if (!last_col) begin
                     mb_col_in = cur_mb_col + CW'(1);
                  end else begin
                     mb_col_in = '0;
                     if (!last_row) begin
                        mb_row_in = cur_mb_row + CW'(1);
                     end else begin
                        mb_row_in     = '0;
                        mb_counter_in = '0;
                     end
                  end
               end
            endcase
         end
      end

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_channel.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff      <= EW'(1);
         eff_h_ff      <= EW'(1);
         luma_size_ff  <= LS_W'(256);
         mb_row_ff     <= '0;
         mb_col_ff     <= '0;
         plane_ff      <= PLANE_Y;
         sample_row_ff <= '0;
         sample_col_ff <= '0;
         mb_counter_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            eff_w_ff     <= eff_w_in;
            eff_h_ff     <= eff_h_in;
            luma_size_ff <= luma_size_in;
         end
         if (accept) begin
            mb_row_ff     <= mb_row_in;
            mb_col_ff     <= mb_col_in;
            plane_ff      <= plane_in;
            sample_row_ff <= sample_row_in;
            sample_col_ff <= sample_col_in;
            mb_counter_ff <= mb_counter_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_channel.valid = rsp_valid_ff;
   assign rsp_channel.word  = rsp_word_ff;

   // end of frame is always also the end of a macroblock
   a_frame_end_is_mb_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.last_of_frame |-> rsp_word_ff.last_of_macroblock)
      else $error("last_of_frame without last_of_macroblock");

   // chroma blocks never reach row or column 8
   a_chroma_row_range: assert property (@(posedge clock) disable iff (reset)
      plane_ff != PLANE_Y |-> !sample_row_ff[3] && !sample_col_ff[3])
      else $error("chroma position outside 8x8 block");

   // a restart word comes out as macroblock 0, luma sample (0,0)
   a_restart_origin: assert property (@(posedge clock) disable iff (reset)
      accept && req_channel.word.restart |=>
         rsp_word_ff.mb_number == '0 && rsp_word_ff.plane == PLANE_Y &&
         rsp_word_ff.row_in_block == 4'd0 && rsp_word_ff.col_in_block == 4'd0)
      else $error("restart did not return to the first sample");

   // an accepted word always leaves a valid response behind
   a_accept_fills_output: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word lost");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking bench for macroblock_fetch_address_generator
// an address predictor in a scoreboard class checks every response word
// depends on mfag_pkg, mfag_channels and the rtl top level

`timescale 1ns / 1ps

import mfag_pkg::*;

class address_scoreboard;
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   logic [7:0]            mb_row;
   logic [7:0]            mb_col;
   plane_type             phase;
   logic [3:0]            sample_row;
   logic [3:0]            sample_col;
   logic [MB_NUM_W-1:0]   mb_count;
   rsp_word_type          expected_words[$];
   int                    mismatches;

   function new();
      width_reg  = 1;
      height_reg = 1;
      mb_row     = 0;
      mb_col     = 0;
      phase      = PLANE_Y;
      sample_row = 0;
      sample_col = 0;
      mb_count   = 0;
      mismatches = 0;
   endfunction

   function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      if (index == CSR_WIDTH_IN_MBS) begin
         width_reg = data;
      end else if (index == CSR_HEIGHT_IN_MBS) begin
         height_reg = data;
      end
   endfunction

   // zero acts as one, anything above the maximum is clamped
   function longint unsigned clamp_mbs(logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function bit is_idle();
      return expected_words.size() == 0;
   endfunction

   // predicts the address word for one accepted request, then steps the walk
   function void note_request(logic restart);
      longint unsigned w;
      longint unsigned h;
      longint unsigned luma_w;
      longint unsigned luma_size;
      longint unsigned base;
      longint unsigned addr;
      logic [3:0]      blk_last;
      bit              last_col;
      bit              last_row;
      bit              last_mb;
      rsp_word_type    e;
      w         = clamp_mbs(width_reg);
      h         = clamp_mbs(height_reg);
      luma_w    = w * 16;
      luma_size = luma_w * h * 16;
      if (restart) begin
         mb_row     = 0;
         mb_col     = 0;
         phase      = PLANE_Y;
         sample_row = 0;
         sample_col = 0;
         mb_count   = 0;
      end
      blk_last = (phase == PLANE_Y) ? LUMA_LAST : CHROMA_LAST;
      // a position at or past the new edge after a resize counts as the edge
      last_col = 64'(mb_col) + 1 >= w;
      last_row = 64'(mb_row) + 1 >= h;
      if (phase == PLANE_Y) begin
         addr = (64'(mb_row) * 16 + 64'(sample_row)) * luma_w
              + 64'(mb_col) * 16 + 64'(sample_col);
      end else begin
         base = luma_size + ((phase == PLANE_CR) ? (luma_size >> 2) : 0);
         addr = base + (64'(mb_row) * 8 + 64'(sample_row)) * (luma_w >> 1)
              + 64'(mb_col) * 8 + 64'(sample_col);
      end
      last_mb = (phase == PLANE_CR) && (sample_row == blk_last) && (sample_col == blk_last);
      e.byte_address       = addr[ADDR_W-1:0];
      e.plane              = phase;
      e.row_in_block       = sample_row;
      e.col_in_block       = sample_col;
      e.mb_number          = mb_count;
      e.last_of_macroblock = last_mb;
      e.last_of_frame      = last_mb && last_col && last_row;
      expected_words.insert(expected_words.size(), e);

      if (sample_col != blk_last) begin
         sample_col++;
      end else begin
         sample_col = 0;
         if (sample_row != blk_last) begin
            sample_row++;
         end else begin
            sample_row = 0;
            if (phase == PLANE_Y) begin
               phase = PLANE_CB;
            end else if (phase == PLANE_CB) begin
               phase = PLANE_CR;
            end else begin
               phase    = PLANE_Y;
               mb_count = mb_count + 1;
               if (!last_col) begin
                  mb_col++;
               end else begin
                  mb_col = 0;
                  if (!last_row) begin
                     mb_row++;
                  end else begin
                     mb_row   = 0;
                     mb_count = 0;
                  end
               end
            end
         end
      end
   endfunction

   function void check_response(rsp_word_type got);
      rsp_word_type e;
      bit           bad;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: addr %0d plane %0d mb %0d",
                     got.byte_address, got.plane, got.mb_number);
         return;
      end
      e   = expected_words.pop_front();
      bad = 0;
      if (got.byte_address !== e.byte_address) bad = 1;
      if (got.plane !== e.plane) bad = 1;
      if (got.row_in_block !== e.row_in_block) bad = 1;
      if (got.col_in_block !== e.col_in_block) bad = 1;
      if (got.mb_number !== e.mb_number) bad = 1;
      if (got.last_of_macroblock !== e.last_of_macroblock) bad = 1;
      if (got.last_of_frame !== e.last_of_frame) bad = 1;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch exp: addr %0d plane %0d row %0d col %0d mb %0d lmb %0b lfr %0b",
                     e.byte_address, e.plane, e.row_in_block, e.col_in_block,
                     e.mb_number, e.last_of_macroblock, e.last_of_frame);
            $display("         got: addr %0d plane %0d row %0d col %0d mb %0d lmb %0b lfr %0b",
                     got.byte_address, got.plane, got.row_in_block, got.col_in_block,
                     got.mb_number, got.last_of_macroblock, got.last_of_frame);
         end
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 400000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   steady;
   int                     cycle_count;

   mfag_req_if req_bus ();
   mfag_rsp_if rsp_bus ();

   address_scoreboard sb = new();

   macroblock_fetch_address_generator dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus)
   );

   always #4 clock = ~clock;

   // receiver drops ready at random about ten percent of the time unless in the steady stretch
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response(rsp_bus.word);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_word(input logic restart);
      req_bus.valid        <= 1'b1;
      req_bus.word.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(restart);
      if (!steady && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   // drain all outstanding words, then a short pause before any register write
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (!sb.is_idle()) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_WIDTH_IN_MBS;
      csr_write_data   <= w;
      @(posedge clock);
      sb.write_register(CSR_WIDTH_IN_MBS, w);
      csr_index      <= CSR_HEIGHT_IN_MBS;
      csr_write_data <= h;
      @(posedge clock);
      sb.write_register(CSR_HEIGHT_IN_MBS, h);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(3))
         0:       return 9'd1;
         1:       return 9'd256;
         default: return CSR_DATA_W'($urandom_range(511));
      endcase
   endfunction

   initial begin
      cycle_count      <= 0;
      reset            <= 1'b1;
      steady           <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_WIDTH_IN_MBS;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.word     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: restarts at the start and mid-walk, size extremes and clamping
      send_word(1'b1);
      repeat (4) send_word(1'b0);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      settle();
      set_frame(9'd256, 9'd256);
      repeat (3) send_word(1'b0);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      settle();
      set_frame(9'd0, 9'd0);
      repeat (2) send_word(1'b0);
      send_word(1'b1);
      settle();
      set_frame(9'd511, 9'd300);
      send_word(1'b1);
      repeat (2) send_word(1'b0);
      settle();

      // two macroblocks across, stopped just inside the second one
      set_frame(9'd2, 9'd1);
      send_word(1'b1);
      for (int i = 0; i < 389; i++) begin
         if (i == 100) steady <= 1'b1;
         if (i == 250) steady <= 1'b0;
         send_word(1'b0);
      end
      settle();
      // shrink under the walk: column past the edge ends the frame and wraps
      set_frame(9'd1, 9'd1);
      repeat (380) send_word(1'b0);
      settle();

      // noisy phases with random sizes and occasional restarts
      for (int p = 0; p < 4; p++) begin
         set_frame(pick_size(), pick_size());
         repeat (50) send_word($urandom_range(99) < 5);
         settle();
      end

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.is_idle()) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
